>>> rtl/gnb_pkg.sv
`default_nettype none
package gnb_pkg;

    localparam int MAX_COLUMNS  = 64;
    localparam int MAX_ROWS     = 64;
    localparam int BUCKET_DEPTH = 8;
    localparam int MAX_RING     = 5;
    localparam int MAX_RESULTS  = 64;

    localparam int DIM_W     = 7;
    localparam int COORD_W   = 8;
    localparam int ID_W      = 16;
    localparam int RAD_W     = 3;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 1;
    localparam int DIM_RESET = 64;

    typedef enum logic [1:0] {
        CMD_ADD,
        CMD_REMOVE,
        CMD_QUERY,
        CMD_CLEAR
    } t_cmd;

    typedef enum logic [2:0] {
        ST_DONE,
        ST_PRESENT,
        ST_FULL,
        ST_OUTSIDE,
        ST_BAD_RADIUS,
        ST_TRUNCATED
    } t_status;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_DECODE,
        S_FILL,
        S_SRD,
        S_SCMP,
        S_SHRD,
        S_SHWR,
        S_QCELL,
        S_QFILL,
        S_QIRD,
        S_QIDAT,
        S_QEND
    } t_state;

endpackage
`default_nettype wire

>>> rtl/gnb_store.sv
`default_nettype none
module gnb_store #(
    parameter int NUM_CELLS    = gnb_pkg::MAX_COLUMNS * gnb_pkg::MAX_ROWS,
    parameter int BUCKET_DEPTH = gnb_pkg::BUCKET_DEPTH,
    localparam int CELL_AW     = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1,
    localparam int ID_AW       = (NUM_CELLS * BUCKET_DEPTH > 1) ?
                                 $clog2(NUM_CELLS * BUCKET_DEPTH) : 1,
    localparam int FILL_W      = $clog2(BUCKET_DEPTH + 1)
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_fill_we,
    input  wire logic [CELL_AW-1:0]                   i_fill_waddr,
    input  wire logic [FILL_W-1:0]                    i_fill_wdata,
    input  wire logic [CELL_AW-1:0]                   i_fill_raddr,
    output logic      [FILL_W-1:0]                    o_fill_rdata,
    input  wire logic                                 i_id_we,
    input  wire logic [ID_AW-1:0]                     i_id_waddr,
    input  wire logic [gnb_pkg::ID_W-1:0]             i_id_wdata,
    input  wire logic [ID_AW-1:0]                     i_id_raddr,
    output logic      [gnb_pkg::ID_W-1:0]             o_id_rdata
);
    logic [FILL_W-1:0]        r_fill_mem [NUM_CELLS];
    logic [gnb_pkg::ID_W-1:0] r_id_mem   [NUM_CELLS * BUCKET_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_fill_we) begin
            r_fill_mem[i_fill_waddr] <= i_fill_wdata;
        end
        o_fill_rdata <= r_fill_mem[i_fill_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_id_we) begin
            r_id_mem[i_id_waddr] <= i_id_wdata;
        end
        o_id_rdata <= r_id_mem[i_id_raddr];
    end

endmodule
`default_nettype wire

>>> rtl/grid_neighbor_bucket_store_core.sv
// Channel   Direction  Handshake                      Payload
// command   in         start & !busy                  i_command i_cell_x i_cell_y
//                                                      i_object_id i_radius
// config    in         i_cfg_valid & o_cfg_ready      i_cfg_index i_cfg_data
// result    out        o_result_valid (one cycle)     o_status o_found_id o_id_valid o_last
//
// Add/remove: searches the bucket slots in turn; remove also shifts the later slots down.
// Query: visits up to 61 cells and reads the ids of each in-grid cell; one fill/id memory
// port each sets the pace.
// Clear: writes all MAX_COLUMNS*MAX_ROWS cells.
// After reset and after each nonzero grid size write a clearing pass over all
// MAX_COLUMNS*MAX_ROWS cells runs with busy high. The receiver cannot stall results.
`default_nettype none
module grid_neighbor_bucket_store_core #(
    parameter int MAX_COLUMNS  = gnb_pkg::MAX_COLUMNS,
    parameter int MAX_ROWS     = gnb_pkg::MAX_ROWS,
    parameter int BUCKET_DEPTH = gnb_pkg::BUCKET_DEPTH,
    parameter int MAX_RING     = gnb_pkg::MAX_RING,
    parameter int MAX_RESULTS  = gnb_pkg::MAX_RESULTS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [1:0]                        i_command,
    input  wire logic signed [gnb_pkg::COORD_W-1:0] i_cell_x,
    input  wire logic signed [gnb_pkg::COORD_W-1:0] i_cell_y,
    input  wire logic [gnb_pkg::ID_W-1:0]          i_object_id,
    input  wire logic [gnb_pkg::RAD_W-1:0]         i_radius,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [gnb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [gnb_pkg::DIM_W-1:0]         i_cfg_data,
    output logic                                   o_result_valid,
    output logic [gnb_pkg::STATUS_W-1:0]           o_status,
    output logic [gnb_pkg::ID_W-1:0]               o_found_id,
    output logic                                   o_id_valid,
    output logic                                   o_last
);
    localparam int NUM_CELLS = MAX_COLUMNS * MAX_ROWS;
    localparam int CELL_AW   = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int ID_AW     = (NUM_CELLS * BUCKET_DEPTH > 1) ?
                               $clog2(NUM_CELLS * BUCKET_DEPTH) : 1;
    localparam int FILL_W    = $clog2(BUCKET_DEPTH + 1);
    localparam int CNT_W     = $clog2(MAX_RESULTS + 1);
    localparam int DIM_W     = gnb_pkg::DIM_W;
    localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'((gnb_pkg::DIM_RESET > MAX_COLUMNS) ?
                                              MAX_COLUMNS : gnb_pkg::DIM_RESET);
    localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'((gnb_pkg::DIM_RESET > MAX_ROWS) ?
                                              MAX_ROWS : gnb_pkg::DIM_RESET);

    gnb_pkg::t_state r_state, n_state;

    gnb_pkg::t_cmd            r_cmd, n_cmd;
    logic signed [7:0]        r_cx, n_cx, r_cy, n_cy;
    logic [gnb_pkg::ID_W-1:0] r_id, n_id;
    logic [2:0]               r_rad, n_rad;
    logic [CELL_AW-1:0]       r_cell, n_cell;
    logic [FILL_W-1:0]        r_n, n_n, r_idx, n_idx;
    logic [2:0]               r_r, n_r;
    logic signed [3:0]        r_dx, n_dx;
    logic                     r_pass, n_pass;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_trunc, n_trunc;
    logic                     r_pend_v, n_pend_v;
    logic [gnb_pkg::ID_W-1:0] r_pend_id, n_pend_id;
    logic [CELL_AW-1:0]       r_clr_addr, n_clr_addr;
    logic                     r_clr_report, n_clr_report;
    logic [DIM_W-1:0]         r_width, n_width, r_height, n_height;

    logic                          r_res_v, n_res_v;
    logic [gnb_pkg::STATUS_W-1:0]  r_res_status, n_res_status;
    logic [gnb_pkg::ID_W-1:0]      r_res_id, n_res_id;
    logic                          r_res_idv, n_res_idv, r_res_last, n_res_last;

    logic                     fill_we;
    logic [CELL_AW-1:0]       fill_waddr, fill_raddr;
    logic [FILL_W-1:0]        fill_wdata, fill_rdata;
    logic                     id_we;
    logic [ID_AW-1:0]         id_waddr, id_raddr;
    logic [gnb_pkg::ID_W-1:0] id_wdata, id_rdata;

    logic                     w_accept;
    logic [DIM_W-1:0]         w_cfg_val;
    logic                     w_cfg_clear;
    logic [2:0]               w_adx, w_rest, w_r1;
    logic signed [9:0]        w_tx, w_ty;
    logic                     w_in_grid;
    logic [CELL_AW-1:0]       w_cell;
    logic [ID_AW-1:0]         w_id_base;
    logic                     w_to_pass1, w_dx_at_r, w_walk_done;
    logic [2:0]               s_r;
    logic signed [3:0]        s_dx;
    logic                     s_pass;

    gnb_store #(
        .NUM_CELLS   (NUM_CELLS),
        .BUCKET_DEPTH(BUCKET_DEPTH)
    ) u_store (
        .i_clk       (i_clk),
        .i_fill_we   (fill_we),
        .i_fill_waddr(fill_waddr),
        .i_fill_wdata(fill_wdata),
        .i_fill_raddr(fill_raddr),
        .o_fill_rdata(fill_rdata),
        .i_id_we     (id_we),
        .i_id_waddr  (id_waddr),
        .i_id_wdata  (id_wdata),
        .i_id_raddr  (id_raddr),
        .o_id_rdata  (id_rdata)
    );

    assign busy        = (r_state != gnb_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;

    always_comb begin
        w_cfg_val = i_cfg_data;
        if (i_cfg_index == gnb_pkg::REG_GRID_WIDTH) begin
            if (int'(i_cfg_data) > MAX_COLUMNS) begin
                w_cfg_val = DIM_W'(MAX_COLUMNS);
            end
        end else begin
            if (int'(i_cfg_data) > MAX_ROWS) begin
                w_cfg_val = DIM_W'(MAX_ROWS);
            end
        end
    end
    assign w_cfg_clear = i_cfg_valid && o_cfg_ready && (w_cfg_val != '0);

    // ring walk
    assign w_adx  = r_dx[3] ? 3'(-r_dx) : r_dx[2:0];
    assign w_rest = r_r - w_adx;
    assign w_r1   = r_r + 3'd1;
    assign w_tx   = 10'(r_cx) + 10'(r_dx);
    assign w_ty   = r_pass ? (10'(r_cy) + $signed({7'd0, w_rest}))
                           : (10'(r_cy) - $signed({7'd0, w_rest}));
    assign w_in_grid = !w_tx[9] && !w_ty[9] &&
                       (w_tx[8:0] < {2'b00, r_width}) && (w_ty[8:0] < {2'b00, r_height});
    assign w_cell    = CELL_AW'(int'(w_tx[7:0]) * MAX_ROWS + int'(w_ty[7:0]));
    assign w_id_base = ID_AW'(int'(r_cell) * BUCKET_DEPTH);

    assign w_to_pass1  = !r_pass && (w_rest != 3'd0);
    assign w_dx_at_r   = (r_dx == $signed({1'b0, r_r}));
    assign w_walk_done = !w_to_pass1 && w_dx_at_r && (r_r == r_rad);

    always_comb begin
        s_r    = r_r;
        s_dx   = r_dx;
        s_pass = 1'b0;
        if (w_to_pass1) begin
            s_pass = 1'b1;
        end else if (w_dx_at_r) begin
            s_r  = w_r1;
            s_dx = -$signed({1'b0, w_r1});
        end else begin
            s_dx = r_dx + 4'sd1;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            gnb_pkg::S_IDLE: begin
                if (w_accept) n_state = gnb_pkg::S_DECODE;
            end
            gnb_pkg::S_CLEAR: begin
                if (r_clr_addr == CELL_AW'(NUM_CELLS - 1)) n_state = gnb_pkg::S_IDLE;
            end
            gnb_pkg::S_DECODE: begin
                case (r_cmd)
                    gnb_pkg::CMD_CLEAR: n_state = gnb_pkg::S_CLEAR;
                    gnb_pkg::CMD_QUERY: n_state = (int'(r_rad) > MAX_RING) ?
                                                  gnb_pkg::S_IDLE : gnb_pkg::S_QCELL;
                    default:            n_state = w_in_grid ? gnb_pkg::S_FILL : gnb_pkg::S_IDLE;
                endcase
            end
            gnb_pkg::S_FILL: n_state = gnb_pkg::S_SRD;
            gnb_pkg::S_SRD: begin
                n_state = (r_idx == r_n) ? gnb_pkg::S_IDLE : gnb_pkg::S_SCMP;
            end
            gnb_pkg::S_SCMP: begin
                if (id_rdata == r_id) begin
                    n_state = (r_cmd == gnb_pkg::CMD_ADD) ? gnb_pkg::S_IDLE : gnb_pkg::S_SHRD;
                end else begin
                    n_state = gnb_pkg::S_SRD;
                end
            end
            gnb_pkg::S_SHRD: begin
                n_state = (({1'b0, r_idx} + 1'b1) < {1'b0, r_n}) ?
                          gnb_pkg::S_SHWR : gnb_pkg::S_IDLE;
            end
            gnb_pkg::S_SHWR: n_state = gnb_pkg::S_SHRD;
            gnb_pkg::S_QCELL: begin
                if (w_in_grid)        n_state = gnb_pkg::S_QFILL;
                else if (w_walk_done) n_state = gnb_pkg::S_QEND;
            end
            gnb_pkg::S_QFILL: n_state = gnb_pkg::S_QIRD;
            gnb_pkg::S_QIRD: begin
                if (r_idx != r_n)     n_state = gnb_pkg::S_QIDAT;
                else if (w_walk_done) n_state = gnb_pkg::S_QEND;
                else                  n_state = gnb_pkg::S_QCELL;
            end
            gnb_pkg::S_QIDAT: begin
                n_state = (r_cnt == CNT_W'(MAX_RESULTS)) ? gnb_pkg::S_QEND : gnb_pkg::S_QIRD;
            end
            gnb_pkg::S_QEND: n_state = gnb_pkg::S_IDLE;
            default:         n_state = gnb_pkg::S_IDLE;
        endcase
        if (w_cfg_clear) n_state = gnb_pkg::S_CLEAR;
    end

    always_comb begin
        n_cmd = r_cmd; n_cx = r_cx; n_cy = r_cy; n_id = r_id; n_rad = r_rad;
        n_cell = r_cell; n_n = r_n; n_idx = r_idx;
        n_r = r_r; n_dx = r_dx; n_pass = r_pass;
        n_cnt = r_cnt; n_trunc = r_trunc; n_pend_v = r_pend_v; n_pend_id = r_pend_id;
        n_clr_addr = r_clr_addr; n_clr_report = r_clr_report;
        n_width = r_width; n_height = r_height;
        n_res_v = 1'b0; n_res_status = r_res_status; n_res_id = r_res_id;
        n_res_idv = r_res_idv; n_res_last = r_res_last;
        fill_we = 1'b0; fill_waddr = r_cell; fill_wdata = '0; fill_raddr = w_cell;
        id_we = 1'b0; id_waddr = w_id_base + ID_AW'(r_idx); id_wdata = r_id;
        id_raddr = w_id_base + ID_AW'(r_idx);

        case (r_state)
            gnb_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_cmd = gnb_pkg::t_cmd'(i_command);
                    n_cx = i_cell_x; n_cy = i_cell_y; n_id = i_object_id; n_rad = i_radius;
                    n_r = 3'd0; n_dx = 4'sd0; n_pass = 1'b0;
                    n_cnt = '0; n_trunc = 1'b0; n_pend_v = 1'b0;
                end
            end
            gnb_pkg::S_CLEAR: begin
                fill_we    = 1'b1;
                fill_waddr = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == CELL_AW'(NUM_CELLS - 1) && r_clr_report) begin
                    n_res_v = 1'b1; n_res_status = gnb_pkg::ST_DONE;
                    n_res_id = '0; n_res_idv = 1'b0; n_res_last = 1'b1;
                end
            end
            gnb_pkg::S_DECODE: begin
                n_res_id = '0; n_res_idv = 1'b0; n_res_last = 1'b1;
                n_cell   = w_cell;
                case (r_cmd)
                    gnb_pkg::CMD_CLEAR: begin
                        n_clr_addr = '0; n_clr_report = 1'b1;
                    end
                    gnb_pkg::CMD_QUERY: begin
                        if (int'(r_rad) > MAX_RING) begin
                            n_res_v = 1'b1; n_res_status = gnb_pkg::ST_BAD_RADIUS;
                        end
                    end
                    default: begin
                        if (!w_in_grid) begin
                            n_res_v = 1'b1; n_res_status = gnb_pkg::ST_OUTSIDE;
                        end
                    end
                endcase
            end
            gnb_pkg::S_FILL: begin
                n_n = fill_rdata; n_idx = '0;
            end
            gnb_pkg::S_SRD: begin
                if (r_idx == r_n) begin
                    n_res_v = 1'b1; n_res_status = gnb_pkg::ST_DONE;
                    if (r_cmd == gnb_pkg::CMD_ADD) begin
                        if (r_n >= FILL_W'(BUCKET_DEPTH)) begin
                            n_res_status = gnb_pkg::ST_FULL;
                        end else begin
                            id_we = 1'b1;
                            fill_we = 1'b1; fill_wdata = r_n + 1'b1;
                        end
                    end
                end
            end
            gnb_pkg::S_SCMP: begin
                if (id_rdata == r_id) begin
                    if (r_cmd == gnb_pkg::CMD_ADD) begin
                        n_res_v = 1'b1; n_res_status = gnb_pkg::ST_PRESENT;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            gnb_pkg::S_SHRD: begin
                id_raddr = w_id_base + ID_AW'(r_idx) + 1'b1;
                if (!(({1'b0, r_idx} + 1'b1) < {1'b0, r_n})) begin
                    fill_we = 1'b1; fill_wdata = r_n - 1'b1;
                    n_res_v = 1'b1; n_res_status = gnb_pkg::ST_DONE;
                end
            end
            gnb_pkg::S_SHWR: begin
                id_we = 1'b1; id_wdata = id_rdata;
                n_idx = r_idx + 1'b1;
            end
            gnb_pkg::S_QCELL: begin
                n_cell = w_cell;
                if (!w_in_grid && !w_walk_done) begin
                    n_r = s_r; n_dx = s_dx; n_pass = s_pass;
                end
            end
            gnb_pkg::S_QFILL: begin
                n_n = fill_rdata; n_idx = '0;
            end
            gnb_pkg::S_QIRD: begin
                if (r_idx == r_n && !w_walk_done) begin
                    n_r = s_r; n_dx = s_dx; n_pass = s_pass;
                end
            end
            gnb_pkg::S_QIDAT: begin
                if (r_cnt == CNT_W'(MAX_RESULTS)) begin
                    n_trunc = 1'b1;
                end else begin
                    if (r_pend_v) begin
                        n_res_v = 1'b1; n_res_status = gnb_pkg::ST_DONE;
                        n_res_id = r_pend_id; n_res_idv = 1'b1; n_res_last = 1'b0;
                    end
                    n_pend_v = 1'b1; n_pend_id = id_rdata;
                    n_cnt = r_cnt + 1'b1; n_idx = r_idx + 1'b1;
                end
            end
            gnb_pkg::S_QEND: begin
                n_res_v = 1'b1; n_res_last = 1'b1;
                n_res_status = r_trunc ? gnb_pkg::ST_TRUNCATED : gnb_pkg::ST_DONE;
                n_res_id  = r_pend_v ? r_pend_id : '0;
                n_res_idv = r_pend_v;
            end
            default: ;
        endcase

        if (w_cfg_clear) begin
            n_clr_addr = '0; n_clr_report = 1'b0;
            if (i_cfg_index == gnb_pkg::REG_GRID_WIDTH) n_width = w_cfg_val;
            else                                        n_height = w_cfg_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= gnb_pkg::S_CLEAR;
            r_clr_addr   <= '0;
            r_clr_report <= 1'b0;
            r_width      <= WIDTH_RST;
            r_height     <= HEIGHT_RST;
            r_res_v      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_clr_report <= n_clr_report;
            r_width      <= n_width;
            r_height     <= n_height;
            r_res_v      <= n_res_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd; r_cx <= n_cx; r_cy <= n_cy; r_id <= n_id; r_rad <= n_rad;
        r_cell <= n_cell; r_n <= n_n; r_idx <= n_idx;
        r_r <= n_r; r_dx <= n_dx; r_pass <= n_pass;
        r_cnt <= n_cnt; r_trunc <= n_trunc; r_pend_v <= n_pend_v; r_pend_id <= n_pend_id;
        r_res_status <= n_res_status; r_res_id <= n_res_id;
        r_res_idv <= n_res_idv; r_res_last <= n_res_last;
    end

    assign o_result_valid = r_res_v;
    assign o_status       = r_res_status;
    assign o_found_id     = r_res_id;
    assign o_id_valid     = r_res_idv;
    assign o_last         = r_res_last;

endmodule
`default_nettype wire

>>> rtl/gnb_checker.sv
`default_nettype none
module gnb_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_result_valid,
    input wire logic [2:0]  o_status,
    input wire logic [15:0] o_found_id,
    input wire logic        o_id_valid,
    input wire logic        o_last
);
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy low after a command transfer");

    a_more_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_last |-> busy)
        else $error("block idle with results still owed");

    a_mid_is_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_last |-> o_id_valid && o_status == gnb_pkg::ST_DONE)
        else $error("non-final result without an id");

    a_no_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_id_valid |-> o_last && o_found_id == 16'd0)
        else $error("result without id is not final or carries data");

    a_id_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_id_valid |->
            o_status == gnb_pkg::ST_DONE || o_status == gnb_pkg::ST_TRUNCATED)
        else $error("id result with error status");

endmodule

bind grid_neighbor_bucket_store_core gnb_checker u_gnb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_result_valid(o_result_valid),
    .o_status      (o_status),
    .o_found_id    (o_found_id),
    .o_id_valid    (o_id_valid),
    .o_last        (o_last)
);
`default_nettype wire
